@@ hw/rtl/gaussian_pair_force_top_macros.svh @@
// Assertion macros used by the gaussian pair force RTL.
`ifndef GAUSSIAN_PAIR_FORCE_TOP_MACROS_SVH
`define GAUSSIAN_PAIR_FORCE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define GPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define GPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gpf_pkg.sv @@
// Package: types, constants and helper functions of the gaussian pair force engine.
`default_nettype none

package gpf_pkg;

  localparam int MAX_TYPES = 16;
  localparam int TYPE_W    = 4;
  localparam int ENTRIES   = MAX_TYPES * MAX_TYPES;
  localparam int IDX_W     = $clog2(ENTRIES);

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [38:0] TCLAMP    = 39'h40_0000_0000;
  localparam logic [40:0] ACLAMP    = 41'h100_0000_0000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PAIR = 1'b1;

  typedef struct packed {
    logic [31:0] amplitude;
    logic [31:0] width;
    logic [31:0] cut_squared;
    logic [31:0] offset;
  } gpf_coef_t;

  typedef struct packed {
    logic        in_cutoff;
    logic [31:0] pair_scalar;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [31:0] pair_energy;
    logic [31:0] occupied_count;
  } gpf_result_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_AUB, S_TLO, S_THI, S_TSUM, S_TQ,
    S_YLO, S_YHI, S_YSUM, S_KF, S_ZI, S_Z, S_Z2I, S_Z2, S_Z3I, S_Z3,
    S_Z4I, S_D6I, S_D24I, S_QSUM, S_MI, S_M, S_XLO, S_XHI, S_XSUM,
    S_FSH, S_FP, S_FXI, S_FYI, S_FZI, S_AMI, S_EN, S_EN2, S_DONE
  } gpf_state_t;

  // 2^(i/8) in Q1.30
  function automatic logic [31:0] pow2_frac(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'd1073741824;
      3'd1:    v = 32'd1170923762;
      3'd2:    v = 32'd1276901417;
      3'd3:    v = 32'd1392470869;
      3'd4:    v = 32'd1518500250;
      3'd5:    v = 32'd1655936265;
      3'd6:    v = 32'd1805811301;
      3'd7:    v = 32'd1969251188;
      default: v = 32'd1073741824;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // clamp a magnitude to int32 range and apply the sign
  function automatic logic [31:0] sat_mag(input logic [95:0] mg, input logic neg);
    logic [31:0] lim;
    logic [31:0] v;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v   = (mg > {64'd0, lim}) ? lim : mg[31:0];
    return neg ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gaussian_pair_force_top.sv @@
// Top level of the gaussian pair force engine: handshake and output register.
//
// Channel  Handshake            Payload
// in       in_valid, in_ready   mode type_i type_j dx dy dz load_* count_enable count_restart
// out      out_valid, out_ready in_cutoff pair_scalar force_x/y/z pair_energy occupied_count
//
// A pair word's 21 products are stepped through one shared 32x32 multiplier.
// For a load word, its coefficient write lands on the accept edge.
// Reset clears the sequencer, the occupancy counter and the output valid flag; the
// coefficient memory keeps its contents and is not cleared.
// A result held by out_ready low waits in the output register while the next word runs.
`default_nettype none

module gaussian_pair_force_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [gpf_pkg::TYPE_W-1:0] type_i,
  input  logic [gpf_pkg::TYPE_W-1:0] type_j,
  input  logic signed [31:0]        dx,
  input  logic signed [31:0]        dy,
  input  logic signed [31:0]        dz,
  input  logic signed [31:0]        load_amplitude,
  input  logic signed [31:0]        load_width,
  input  logic [31:0]               load_cut_squared,
  input  logic signed [31:0]        load_offset,
  input  logic                      count_enable,
  input  logic                      count_restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      in_cutoff,
  output logic signed [31:0]        pair_scalar,
  output logic signed [31:0]        force_x,
  output logic signed [31:0]        force_y,
  output logic signed [31:0]        force_z,
  output logic signed [31:0]        pair_energy,
  output logic [31:0]               occupied_count
);
  import gpf_pkg::*;

  logic        idle, res_valid, res_take;
  gpf_coef_t   coef_in;
  gpf_result_t res, out_res;

  assign coef_in.amplitude   = load_amplitude;
  assign coef_in.width       = load_width;
  assign coef_in.cut_squared = load_cut_squared;
  assign coef_in.offset      = load_offset;

  assign in_ready = idle;
  assign res_take = res_valid && (!out_valid || out_ready);

  gpf_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (in_valid && in_ready),
    .mode          (mode),
    .type_i        (type_i),
    .type_j        (type_j),
    .dx            (dx),
    .dy            (dy),
    .dz            (dz),
    .coef_in       (coef_in),
    .count_enable  (count_enable),
    .count_restart (count_restart),
    .idle          (idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign in_cutoff      = out_res.in_cutoff;
  assign pair_scalar    = out_res.pair_scalar;
  assign force_x        = out_res.force_x;
  assign force_y        = out_res.force_y;
  assign force_z        = out_res.force_z;
  assign pair_energy    = out_res.pair_energy;
  assign occupied_count = out_res.occupied_count;

endmodule

`default_nettype wire

@@ hw/rtl/gpf_coef_ram.sv @@
// Coefficient memory: one word per ordered type pair, registered read.
`default_nettype none

module gpf_coef_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [gpf_pkg::IDX_W-1:0] waddr,
  input  gpf_pkg::gpf_coef_t       wdata,
  input  logic                     re,
  input  logic [gpf_pkg::IDX_W-1:0] raddr,
  output gpf_pkg::gpf_coef_t       rdata
);
  import gpf_pkg::*;

  gpf_coef_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpf_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none

module gpf_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  import gpf_pkg::*;

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpf_core.sv @@
// Sequencer and datapath: coefficient lookup, exp approximation, force, energy, count.
`default_nettype none
`include "gaussian_pair_force_top_macros.svh"

module gpf_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mode,
  input  logic [gpf_pkg::TYPE_W-1:0] type_i,
  input  logic [gpf_pkg::TYPE_W-1:0] type_j,
  input  logic [31:0]               dx,
  input  logic [31:0]               dy,
  input  logic [31:0]               dz,
  input  gpf_pkg::gpf_coef_t        coef_in,
  input  logic                      count_enable,
  input  logic                      count_restart,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_take,
  output gpf_pkg::gpf_result_t      res
);
  import gpf_pkg::*;

  gpf_state_t state, state_next;

  logic             ok, ok_q, is_pair, ce_q, cr_q;
  logic [IDX_W-1:0] idx;
  logic [31:0]      dx_q, dy_q, dz_q;
  gpf_coef_t        rdata;
  logic [31:0]      ca, cb, ccut, coff;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [63:0]       rsq, aub;
  logic [95:0]       acc;
  logic [38:0]       tq, y;
  logic              occ, in_cut, big;
  logic signed [7:0] k;
  logic [31:0]       f, z, z2, z3, z4, q, m;
  logic [31:0]       fpair, fx, fy, fz, energy;
  logic [40:0]       ev;
  logic [31:0]       cnt, cnt_base, cnt_next;

  logic              bpos;
  logic [8:0]        s_fp, s_en;
  logic [95:0]       ysum;
  logic [63:0]       am_sh;
  logic [40:0]       ev_raw;
  logic [41:0]       e_wide;

  assign ok  = (int'(type_i) < MAX_TYPES) && (int'(type_j) < MAX_TYPES);
  assign idx = IDX_W'(int'(type_i) * MAX_TYPES + int'(type_j));

  gpf_coef_ram u_ram (
    .clk   (clk),
    .we    (start && mode == MODE_LOAD && ok),
    .waddr (idx),
    .wdata (coef_in),
    .re    (start && mode == MODE_PAIR),
    .raddr (idx),
    .rdata (rdata)
  );

  gpf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE:  if (start) state_next = (mode == MODE_PAIR) ? S_SQX : S_DONE;
      S_SQX:   begin mul_a = mag32(dx_q); mul_b = mag32(dx_q); state_next = S_SQY; end
      S_SQY:   begin mul_a = mag32(dy_q); mul_b = mag32(dy_q); state_next = S_SQZ; end
      S_SQZ:   begin mul_a = mag32(dz_q); mul_b = mag32(dz_q); state_next = S_AUB; end
      S_AUB:   begin mul_a = mag32(ca); mul_b = mag32(cb); state_next = S_TLO; end
      S_TLO:   begin mul_a = mag32(cb); mul_b = rsq[31:0]; state_next = S_THI; end
      S_THI:   begin mul_a = mag32(cb); mul_b = rsq[63:32]; state_next = S_TSUM; end
      S_TSUM:  state_next = S_TQ;
      S_TQ:    state_next = S_YLO;
      S_YLO:   begin mul_a = tq[31:0]; mul_b = LOG2E_Q30; state_next = S_YHI; end
      S_YHI:   begin mul_a = {25'd0, tq[38:32]}; mul_b = LOG2E_Q30; state_next = S_YSUM; end
      S_YSUM:  state_next = S_KF;
      S_KF:    state_next = S_ZI;
      S_ZI:    begin mul_a = {3'd0, f[28:0]}; mul_b = LN2_Q32; state_next = S_Z; end
      S_Z:     state_next = S_Z2I;
      S_Z2I:   begin mul_a = z; mul_b = z; state_next = S_Z2; end
      S_Z2:    state_next = S_Z3I;
      S_Z3I:   begin mul_a = z2; mul_b = z; state_next = S_Z3; end
      S_Z3:    state_next = S_Z4I;
      S_Z4I:   begin mul_a = z3; mul_b = z; state_next = S_D6I; end
      S_D6I:   begin mul_a = z3; mul_b = RECIP3; state_next = S_D24I; end
      S_D24I:  begin mul_a = z4; mul_b = RECIP3; state_next = S_QSUM; end
      S_QSUM:  state_next = S_MI;
      S_MI:    begin mul_a = pow2_frac(f[31:29]); mul_b = q; state_next = S_M; end
      S_M:     state_next = S_XLO;
      S_XLO:   begin mul_a = aub[31:0]; mul_b = m; state_next = S_XHI; end
      S_XHI:   begin mul_a = aub[63:32]; mul_b = m; state_next = S_XSUM; end
      S_XSUM:  state_next = S_FSH;
      S_FSH:   state_next = S_FP;
      S_FP:    state_next = S_FXI;
      S_FXI:   begin mul_a = mag32(dx_q); mul_b = mag32(fpair); state_next = S_FYI; end
      S_FYI:   begin mul_a = mag32(dy_q); mul_b = mag32(fpair); state_next = S_FZI; end
      S_FZI:   begin mul_a = mag32(dz_q); mul_b = mag32(fpair); state_next = S_AMI; end
      S_AMI:   begin mul_a = mag32(ca); mul_b = m; state_next = S_EN; end
      S_EN:    state_next = S_EN2;
      S_EN2:   state_next = S_DONE;
      S_DONE:  if (res_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // step values
  assign bpos = !cb[31] && (cb != 32'd0);
  assign s_fp = 9'd45 - {k[7], k};
  assign s_en = 9'd30 - {k[7], k};
  assign ysum = acc + {prod, 32'd0};
  assign am_sh = prod >> s_en[5:0];

  always_comb begin
    if (s_en[8]) begin
      ev_raw = (prod != 64'd0) ? ACLAMP : 41'd0;
    end else if (s_en[7:6] != 2'd0) begin
      ev_raw = 41'd0;
    end else if (am_sh > {23'd0, ACLAMP}) begin
      ev_raw = ACLAMP;
    end else begin
      ev_raw = am_sh[40:0];
    end
  end

  assign e_wide = ca[31] ? ({{10{coff[31]}}, coff} + {1'b0, ev})
                         : ({{10{coff[31]}}, coff} - {1'b0, ev});

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          dx_q    <= dx;
          dy_q    <= dy;
          dz_q    <= dz;
          ce_q    <= count_enable;
          cr_q    <= count_restart;
          ok_q    <= ok;
          is_pair <= (mode == MODE_PAIR);
          in_cut  <= 1'b0;
        end
      end
      S_SQX: begin
        ca   <= rdata.amplitude;
        cb   <= rdata.width;
        ccut <= rdata.cut_squared;
        coff <= rdata.offset;
      end
      S_SQY:  rsq <= prod;
      S_SQZ:  rsq <= rsq + prod;
      S_AUB:  rsq <= rsq + prod;
      S_TLO:  aub <= prod;
      S_THI:  acc <= {32'd0, prod};
      S_TSUM: acc <= acc + {prod, 32'd0};
      S_TQ: begin
        tq     <= (acc[95:16] > {41'd0, TCLAMP}) ? TCLAMP : acc[54:16];
        occ    <= !cb[31] && (acc[95:47] == '0);
        in_cut <= ok_q && (rsq < {16'd0, ccut, 16'd0});
      end
      S_YHI:  acc <= {32'd0, prod};
      S_YSUM: y <= ysum[68:30];
      S_KF: begin
        k <= bpos ? (8'd0 - {1'b0, y[38:32]} - {7'd0, (y[31:0] != 32'd0)})
                  : {1'b0, y[38:32]};
        f <= bpos ? (32'd0 - y[31:0]) : y[31:0];
      end
      S_Z:    z  <= prod[63:32];
      S_Z2:   z2 <= prod[63:32];
      S_Z3:   z3 <= prod[63:32];
      S_D6I:  z4 <= prod[63:32];
      S_D24I: q  <= z + {1'b0, z2[31:1]} + {2'd0, prod[63:34]};
      S_QSUM: q  <= q + {4'd0, prod[63:36]};
      S_M:    m  <= pow2_frac(f[31:29]) + prod[63:32];
      S_XHI:  acc <= {32'd0, prod};
      S_XSUM: acc <= acc + {prod, 32'd0};
      S_FSH: begin
        big <= s_fp[8] && (acc != '0);
        acc <= s_fp[8] ? '0 : (acc >> s_fp[7:0]);
      end
      S_FP:   fpair <= sat_mag(big ? {32'd1, 64'd0} : acc, ca[31] == cb[31]);
      S_FYI:  fx <= sat_mag(96'(prod[63:16]), dx_q[31] ^ fpair[31]);
      S_FZI:  fy <= sat_mag(96'(prod[63:16]), dy_q[31] ^ fpair[31]);
      S_AMI:  fz <= sat_mag(96'(prod[63:16]), dz_q[31] ^ fpair[31]);
      S_EN:   ev <= ev_raw;
      S_EN2: begin
        if (!e_wide[41] && e_wide[40:31] != '0) begin
          energy <= 32'h7FFF_FFFF;
        end else if (e_wide[41] && e_wide[40:31] != '1) begin
          energy <= 32'h8000_0000;
        end else begin
          energy <= e_wide[31:0];
        end
      end
      default: ;
    endcase
  end

  // occupancy counter
  assign cnt_base = cr_q ? 32'd0 : cnt;
  assign cnt_next = !is_pair ? cnt
                  : cnt_base + {31'd0, (ce_q && occ && ok_q && cnt_base != '1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (res_take) begin
      cnt <= cnt_next;
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.in_cutoff      = in_cut;
    res.pair_scalar    = in_cut ? fpair : 32'd0;
    res.force_x        = in_cut ? fx : 32'd0;
    res.force_y        = in_cut ? fy : 32'd0;
    res.force_z        = in_cut ? fz : 32'd0;
    res.pair_energy    = in_cut ? energy : 32'd0;
    res.occupied_count = cnt_next;
  end

  `GPF_ASSERT_NEXT(a_start_busy, start, state != S_IDLE, "accepted word left sequencer idle")
  `GPF_ASSERT_NEXT(a_cnt_grows, res_take && !cr_q, cnt >= $past(cnt), "count fell without restart")
  `GPF_ASSERT_SAME(a_out_zero, res_valid && !in_cut, res.pair_scalar == 32'd0 && res.pair_energy == 32'd0 && res.force_x == 32'd0, "nonzero result outside cutoff")
  `GPF_ASSERT_SAME(a_take_done, res_take, res_valid, "result taken while not done")

endmodule

`default_nettype wire

@@ sim/tb_gaussian_pair_force_top.sv @@
// Testbench for the gaussian pair force engine: table of directed words, random words, scoreboard.
`default_nettype none

module tb_gaussian_pair_force_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gpf_pkg::*;

  localparam int  RANDOM_WORDS = 1530;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam real Q1           = 65536.0;

  typedef struct {
    logic        mode;
    logic [3:0]  ti;
    logic [3:0]  tj;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] amp;
    logic [31:0] wid;
    logic [31:0] cut;
    logic [31:0] off;
    logic        cnt_en;
    logic        cnt_clr;
  } word_t;

  typedef struct {
    word_t       w;
    bit          known;
    gpf_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [3:0] type_i = '0, type_j = '0;
  logic signed [31:0] dx = '0, dy = '0, dz = '0;
  logic signed [31:0] load_amplitude = '0, load_width = '0, load_offset = '0;
  logic [31:0] load_cut_squared = '0;
  logic count_enable = 1'b0, count_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic in_cutoff;
  logic signed [31:0] pair_scalar, force_x, force_y, force_z, pair_energy;
  logic [31:0] occupied_count;

  gaussian_pair_force_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .type_i(type_i), .type_j(type_j),
    .dx(dx), .dy(dy), .dz(dz),
    .load_amplitude(load_amplitude), .load_width(load_width),
    .load_cut_squared(load_cut_squared), .load_offset(load_offset),
    .count_enable(count_enable), .count_restart(count_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .in_cutoff(in_cutoff), .pair_scalar(pair_scalar),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .pair_energy(pair_energy), .occupied_count(occupied_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // coefficient shadow and occupancy counter
  logic [31:0] amp_mem [ENTRIES];
  logic [31:0] wid_mem [ENTRIES];
  logic [31:0] cut_mem [ENTRIES];
  logic [31:0] off_mem [ENTRIES];
  bit          written [ENTRIES];
  logic [31:0] occ_count;

  gpf_result_t pending_results[$];
  int unsigned cycles = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          pairs_sent = 0, loads_sent = 0, inside_seen = 0;
  bit          burst = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("tb_gaussian_pair_force_top: done, errors");
      $finish;
    end
  end

  function automatic longint unsigned mag(input logic [31:0] v);
    longint s;
    s = longint'($signed(v));
    return s < 0 ? longint'(-s) : longint'(s);
  endfunction

  function automatic logic [31:0] clamp_signed(input logic [127:0] mg, input bit neg);
    logic [127:0] lim;
    logic [31:0]  v;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    v = (mg > lim) ? lim[31:0] : mg[31:0];
    return neg ? (~v + 32'd1) : v;
  endfunction

  // exp(-b*rsq) as mant * 2^k, mant in Q1.30
  function automatic void exp_split(input logic [31:0] b, input longint unsigned rsq,
                                    output longint unsigned mant, output int k);
    logic [127:0] t;
    longint unsigned tq, y, ip, fp, f, r, z, z2, z3, z4, p, tab;
    t = (128'(mag(b)) * 128'(rsq)) >> 16;
    tq = (t > 128'(64'd64 << 32)) ? (64'd64 << 32) : t[63:0];
    t = (128'(tq) * 128'(LOG2E_Q30)) >> 30;
    y = t[63:0];
    ip = y >> 32;
    fp = y & 64'hFFFF_FFFF;
    if (!b[31] && b != 0) begin
      if (fp != 0) begin
        k = -int'(ip) - 1;
        f = 64'h1_0000_0000 - fp;
      end else begin
        k = -int'(ip);
        f = 0;
      end
    end else begin
      k = int'(ip);
      f = fp;
    end
    r = f & 64'h1FFF_FFFF;
    z = (r * 64'(LN2_Q32)) >> 32;
    z2 = (z * z) >> 32;
    z3 = (z2 * z) >> 32;
    z4 = (z3 * z) >> 32;
    p = 64'h1_0000_0000 + z + z2 / 2 + z3 / 6 + z4 / 24;
    case ((f >> 29) & 7)
      0: tab = 1073741824;
      1: tab = 1170923762;
      2: tab = 1276901417;
      3: tab = 1392470869;
      4: tab = 1518500250;
      5: tab = 1655936265;
      6: tab = 1805811301;
      default: tab = 1969251188;
    endcase
    mant = (tab * p) >> 32;
  endfunction

  function automatic logic [31:0] scale_force(input logic [31:0] d, input logic [31:0] fp);
    longint unsigned m;
    m = (mag(d) * mag(fp)) >> 16;
    return clamp_signed(128'(m), (d[31] != fp[31]) && m != 0);
  endfunction

  function automatic gpf_result_t gauss_pair_predict(input word_t w);
    gpf_result_t     res;
    int              idx, k, s;
    logic [31:0]     a, b;
    longint unsigned rsq, ua, ub, m, am, v;
    longint          en;
    logic [127:0]    x;
    res = '0;
    idx = int'(w.ti) * MAX_TYPES + int'(w.tj);
    if (w.mode == MODE_LOAD) begin
      amp_mem[idx] = w.amp;
      wid_mem[idx] = w.wid;
      cut_mem[idx] = w.cut;
      off_mem[idx] = w.off;
      written[idx] = 1;
    end else begin
      if (w.cnt_clr) occ_count = 0;
      a = amp_mem[idx];
      b = wid_mem[idx];
      ua = mag(a);
      ub = mag(b);
      rsq = mag(w.dx) * mag(w.dx) + mag(w.dy) * mag(w.dy) + mag(w.dz) * mag(w.dz);
      if (w.cnt_en && !b[31] && (ub == 0 || rsq <= ((64'd1 << 47) - 1) / ub)
          && occ_count != 32'hFFFF_FFFF)
        occ_count++;
      if (rsq < (64'(cut_mem[idx]) << 16)) begin
        exp_split(b, rsq, m, k);
        res.in_cutoff = 1'b1;
        x = 128'(ua * ub) * 128'(m);
        s = 45 - k;
        if (s < 0 && x != 0) x = 128'd1 << 64;
        else if (s >= 128) x = 0;
        else if (s > 0) x = x >> s;
        res.pair_scalar = clamp_signed(x, (a[31] == b[31]) && x != 0);
        res.force_x = scale_force(w.dx, res.pair_scalar);
        res.force_y = scale_force(w.dy, res.pair_scalar);
        res.force_z = scale_force(w.dz, res.pair_scalar);
        am = ua * m;
        s = 30 - k;
        if (s < 0) v = (am != 0) ? 64'(ACLAMP) : 0;
        else if (s >= 64) v = 0;
        else v = am >> s;
        if (v > 64'(ACLAMP)) v = 64'(ACLAMP);
        en = longint'($signed(off_mem[idx])) - (a[31] ? -longint'(v) : longint'(v));
        if (en > 64'sd2147483647) en = 64'sd2147483647;
        if (en < -64'sd2147483648) en = -64'sd2147483648;
        res.pair_energy = en[31:0];
        inside_seen++;
      end
    end
    res.occupied_count = occ_count;
    return res;
  endfunction

  function automatic row_t ld(input int ti, input int tj, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c,
                              input logic [31:0] o);
    row_t r;
    r = '{w: '{MODE_LOAD, 4'(ti), 4'(tj), $urandom, $urandom, $urandom, a, b, c, o,
               1'b1, 1'b1}, known: 1, res: '0};
    return r;
  endfunction

  function automatic row_t pr(input int ti, input int tj, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input bit en, input bit clr);
    row_t r;
    r = '{w: '{MODE_PAIR, 4'(ti), 4'(tj), x, y, z, $urandom, $urandom, $urandom, $urandom,
               en, clr}, known: 0, res: '0};
    return r;
  endfunction

  function automatic logic [31:0] rand_disp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
    if (sel < 9) return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    return $urandom;
  endfunction

  function automatic word_t rand_load(input int ti, input int tj);
    word_t w;
    int    sel;
    w = '{MODE_LOAD, 4'(ti), 4'(tj), $urandom, $urandom, $urandom, '0, '0, '0, '0,
          1'($urandom), 1'($urandom)};
    w.amp = ($urandom_range(0, 3) == 0) ? $urandom
          : 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
    sel = $urandom_range(0, 9);
    if (sel < 5) w.wid = $urandom_range(0, 2 ** 17);
    else if (sel < 7) w.wid = 32'(-$signed($urandom_range(0, 2 ** 12)));
    else w.wid = $urandom;
    w.cut = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 2 ** 20) : $urandom;
    w.off = ($urandom_range(0, 1) == 0) ? $urandom
          : 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
    return w;
  endfunction

  task automatic send_word(input word_t w, input bit known, input gpf_result_t typed);
    int gap;
    gpf_result_t got;
    gap = burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = w.mode;
    type_i = w.ti;
    type_j = w.tj;
    dx = w.dx;
    dy = w.dy;
    dz = w.dz;
    load_amplitude = w.amp;
    load_width = w.wid;
    load_cut_squared = w.cut;
    load_offset = w.off;
    count_enable = w.cnt_en;
    count_restart = w.cnt_clr;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = gauss_pair_predict(w);
    pending_results.push_back(known ? typed : got);
    if (w.mode == MODE_LOAD) loads_sent++;
    else pairs_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // result side
  initial begin
    int gap;
    gpf_result_t exp_r, got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{in_cutoff, pair_scalar, force_x, force_y, force_z, pair_energy,
              occupied_count};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  exp: cut=%0d f=%h fx=%h fy=%h fz=%h e=%h n=%0d",
                     exp_r.in_cutoff, exp_r.pair_scalar, exp_r.force_x, exp_r.force_y,
                     exp_r.force_z, exp_r.pair_energy, exp_r.occupied_count);
            $display("  got: cut=%0d f=%h fx=%h fy=%h fz=%h e=%h n=%0d",
                     got.in_cutoff, got.pair_scalar, got.force_x, got.force_y,
                     got.force_z, got.pair_energy, got.occupied_count);
          end
        end
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    row_t        dir_tab[$];
    word_t       w;
    gpf_result_t typed;
    int          ti, tj;
    for (int i = 0; i < ENTRIES; i++) written[i] = 0;
    occ_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_tab.push_back(ld(0, 0, 32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 32'h0));
    dir_tab.push_back(ld(15, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
    dir_tab.push_back(ld(3, 7, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    dir_tab.push_back(ld(1, 2, 32'h0, 32'h0, 32'h0, 32'h0));
    dir_tab.push_back(ld(2, 1, 32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'd12345));
    dir_tab.push_back(ld(5, 10, 32'h0002_0000, 32'hFFFF_F000, 32'h0010_0000, 32'hFFFF_0000));
    dir_tab.push_back(pr(0, 0, 0, 0, 0, 1, 0));
    dir_tab.push_back(pr(0, 0, 32'h0001_0000, 0, 0, 1, 0));
    dir_tab.push_back(pr(0, 0, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 1, 0));
    dir_tab.push_back(pr(0, 0, 32'h0002_0000, 0, 0, 1, 0));
    dir_tab.push_back(pr(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0));
    dir_tab.push_back(pr(15, 15, 0, 0, 0, 1, 0));
    dir_tab.push_back(pr(15, 15, 1, 32'hFFFF_FFFF, 0, 1, 0));
    dir_tab.push_back(pr(15, 15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0));
    dir_tab.push_back(pr(3, 7, 0, 0, 0, 1, 0));
    dir_tab.push_back(pr(3, 7, 32'h0000_0100, 32'h0, 32'h0, 1, 0));
    dir_tab.push_back(pr(3, 7, 32'h0010_0000, 32'hFFF0_0000, 32'h0, 0, 0));
    dir_tab.push_back(pr(2, 1, 32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 1, 0));
    dir_tab.push_back(pr(5, 10, 32'h0001_0000, 32'h0001_0000, 32'h0, 1, 0));
    dir_tab.push_back(pr(5, 10, 32'h0000_4000, 0, 0, 0, 0));
    // zero cutoff with restart: nothing inside, counter cleared
    dir_tab.push_back(pr(1, 2, 32'h0000_0001, 0, 0, 0, 1));
    dir_tab[$].known = 1;
    dir_tab.push_back(pr(0, 0, 0, 0, 0, 1, 1));

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].known, dir_tab[i].res);
    drop_valid();
    // hold off until the engine drains
    while (pending_results.size() != 0) @(posedge clk);

    // fill every entry so random pairs never touch an unwritten one
    for (int i = 0; i < ENTRIES; i++) begin
      w = rand_load(i / MAX_TYPES, i % MAX_TYPES);
      send_word(w, 0, typed);
    end

    for (int n = 0; n < RANDOM_WORDS - ENTRIES; n++) begin
      if (n % 200 == 0) burst = 1;
      if (n % 200 == 40) burst = 0;
      ti = $urandom_range(0, MAX_TYPES - 1);
      tj = $urandom_range(0, MAX_TYPES - 1);
      if ($urandom_range(0, 9) < 2) begin
        w = rand_load(ti, tj);
      end else begin
        w = '{MODE_PAIR, 4'(ti), 4'(tj), rand_disp(), rand_disp(), rand_disp(),
              $urandom, $urandom, $urandom, $urandom,
              1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 19) == 0)};
      end
      send_word(w, 0, typed);
    end
    burst = 0;
    drop_valid();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("sent %0d pair words and %0d coefficient loads; %0d results checked",
             pairs_sent, loads_sent, results_seen);
    $display("%0d pairs fell inside their cutoff, %0d mismatches", inside_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_gaussian_pair_force_top: done, clean");
    end else begin
      $display("tb_gaussian_pair_force_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/gpf_pkg.sv
hw/rtl/gpf_coef_ram.sv
hw/rtl/gpf_mul.sv
hw/rtl/gpf_core.sv
hw/rtl/gaussian_pair_force_top.sv
sim/tb_gaussian_pair_force_top.sv
